[sv/sle_pkg.sv]
// shared constants, result kinds and key tables of the scan code line editor
`default_nettype none

package sle_pkg;

    // result kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ECHO  = 2'd0;
    localparam kind_t KIND_ERASE = 2'd1;
    localparam kind_t KIND_LINE  = 2'd2;
    localparam kind_t KIND_DROP  = 2'd3;

    // register indexes of the configuration port
    localparam logic REG_LAYOUT = 1'b0;
    localparam logic REG_ENABLE = 1'b1;

    // scan codes and characters
    localparam logic [6:0] KEY_BACKSPACE = 7'd14;
    localparam logic [6:0] KEY_LSHIFT    = 7'd42;
    localparam logic [6:0] KEY_CAPS      = 7'd58;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_ERASE      = 8'h08;
    localparam logic [7:0] CH_NONE       = 8'h00;

    // [layout * 2 + upper][key], keys 60 to 63 unmapped
    localparam logic [7:0] KEY_TABLE [0:3][0:63] = '{
        '{8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
          8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
          8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
          8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
          8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
          8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
          8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
          8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
          8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
          8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
          8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h26, 8'h82, 8'h22, 8'h27, 8'h28, 8'h2D, 8'h8A, 8'h5F,
          8'h87, 8'hA0, 8'h29, 8'h3D, 8'h08, 8'h09, 8'h61, 8'h7A, 8'h65, 8'h72,
          8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5E, 8'h24, 8'h0A, 8'h00,
          8'h71, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h6D,
          8'h00, 8'h60, 8'h00, 8'h2A, 8'h77, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
          8'h2C, 8'h3B, 8'h3A, 8'h21, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
          8'h39, 8'h30, 8'h2B, 8'h00, 8'h08, 8'h09, 8'h41, 8'h5A, 8'h45, 8'h52,
          8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'hF9, 8'h9C, 8'h0A, 8'h00,
          8'h51, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h4D,
          8'h25, 8'hE6, 8'h00, 8'h23, 8'h57, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
          8'h3F, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00}
    };

endpackage

`default_nettype wire

[sv/scancode_line_editor.sv]
// scan code line editor: key translation, line store and line replay
// flow: an item is taken into an input register in the idle state and decoded in the exec
// state once the output register is free; a single result is then loaded into the output register
// the block takes no new item while it decodes one or replays; enter replays the line byte by
// byte (one store read, one output load per byte) and then sends the newline
// reset: synchronous active-low aresetn clears length, shift, state and output
// valid; layout resets to AZERTY and editing to enabled; line store is not cleared
`default_nettype none

module scancode_line_editor
    import sle_pkg::*;
#(
    parameter int LINE_DEPTH = 63   // line store entries, 1 to 63
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration write port
    input  wire         cfg_we,
    input  wire         cfg_addr,
    input  wire         cfg_wdata,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] raw_code
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,    // [1:0] kind, [9:2] char_code, [15:10] zero
    output logic        m_tlast     // last
);

    localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // controller states
    localparam logic [1:0] ST_IDLE    = 2'd0;  // waiting for an item
    localparam logic [1:0] ST_EXEC    = 2'd1;  // decode held item
    localparam logic [1:0] ST_DUMP_RD = 2'd2;  // read next stored byte
    localparam logic [1:0] ST_DUMP_WR = 2'd3;  // send read byte, or newline when done

    logic [1:0]        state_reg, state_next;
    logic [7:0]        raw_reg;
    logic              layout_reg, enable_reg;
    logic              shift_reg, shift_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              nl_reg, nl_next;  // replay finished, newline pending

    // line store, one write and one registered read port
    logic [7:0]        line_mem [LINE_DEPTH];
    logic              mem_we, mem_re;
    logic [7:0]        mem_q;

    // output register
    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [7:0]        out_char_reg;
    logic              out_last_reg;
    logic              out_load;
    logic [1:0]        out_kind;
    logic [7:0]        out_char;
    logic              out_last;
    logic              out_free;

    // decode of the held item
    logic [6:0]        key;
    logic              press;
    logic [7:0]        ch;

    assign key      = raw_reg[6:0];
    assign press    = ~raw_reg[7];
    assign ch       = key[6] ? CH_NONE : KEY_TABLE[{layout_reg, shift_reg}][key[5:0]];
    assign out_free = ~out_valid_reg | m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_char_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

    always_comb begin
        state_next = state_reg;
        shift_next = shift_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        nl_next    = nl_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        out_load   = 1'b0;
        out_kind   = KIND_ECHO;
        out_char   = ch;
        out_last   = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait for a free output slot, so every branch may emit
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (key == KEY_LSHIFT) begin
                        shift_next = press;
                    end else if (key == KEY_CAPS) begin
                        if (press) begin
                            shift_next = ~shift_reg;
                        end
                    end else if (!press || !enable_reg) begin
                        // releases and disabled editing do nothing
                    end else if (key == KEY_BACKSPACE) begin
                        if (len_reg != '0) begin
                            len_next = len_reg - 1'b1;
                            out_load = 1'b1;
                            out_kind = KIND_ERASE;
                            out_char = CH_ERASE;
                        end
                    end else if (ch == CH_NONE) begin
                        // unmapped key
                    end else if (ch == CH_NEWLINE) begin
                        idx_next   = '0;
                        nl_next    = (len_reg == '0);
                        state_next = (len_reg == '0) ? ST_DUMP_WR : ST_DUMP_RD;
                    end else if (len_reg >= LEN_W'(LINE_DEPTH)) begin
                        out_load = 1'b1;
                        out_kind = KIND_DROP;
                    end else begin
                        mem_we   = 1'b1;
                        len_next = len_reg + 1'b1;
                        out_load = 1'b1;
                    end
                end
            end
            ST_DUMP_RD: begin
                mem_re     = 1'b1;
                state_next = ST_DUMP_WR;
            end
            ST_DUMP_WR: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (nl_reg) begin
                        out_kind   = KIND_ECHO;
                        out_char   = CH_NEWLINE;
                        len_next   = '0;
                        nl_next    = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        out_kind = KIND_LINE;
                        out_char = mem_q;
                        out_last = 1'b0;
                        idx_next = idx_reg + 1'b1;
                        if (LEN_W'(idx_reg) + 1'b1 == len_reg) begin
                            nl_next = 1'b1;
                        end else begin
                            state_next = ST_DUMP_RD;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            shift_reg     <= 1'b0;
            len_reg       <= '0;
            idx_reg       <= '0;
            nl_reg        <= 1'b0;
            layout_reg    <= 1'b1;
            enable_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            shift_reg <= shift_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            nl_reg    <= nl_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_LAYOUT: layout_reg <= cfg_wdata;
                    REG_ENABLE: enable_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            raw_reg <= s_tdata;
        end
        if (out_load) begin
            out_kind_reg <= out_kind;
            out_char_reg <= out_char;
            out_last_reg <= out_last;
        end
    end

    // line store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[len_reg[ADDR_W-1:0]] <= ch;
        end
        if (mem_re) begin
            mem_q <= line_mem[idx_reg];
        end
    end

`ifndef SYNTHESIS
    // line length stays within the store
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(LINE_DEPTH))
        else $error("line length beyond store depth");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");

    // replay reads only stored entries
    a_read_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP_RD) |-> (LEN_W'(idx_reg) < len_reg))
        else $error("replay read past line end");

    // sending the newline empties the line
    a_nl_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP_WR && nl_reg && out_free) |=> (len_reg == '0))
        else $error("line not cleared after newline");
`endif

endmodule

`default_nettype wire

[sim/scancode_line_editor_check.sv]
// result checker for the scan code line editor: predicts, queues and compares results

module scancode_line_editor_check
    import sle_pkg::*;
#(
    parameter int LINE_DEPTH = 63
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_we,
    input  wire        cfg_addr,
    input  wire        cfg_wdata,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire [7:0]  s_tdata,     // [7:0] raw_code
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [15:0] m_tdata,     // [1:0] kind, [9:2] char_code, [15:10] zero
    input  wire        m_tlast,     // last
    output int         bad_results,
    output int         owed_count
);

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_code;
        logic       last;
    } editor_result_t;

    localparam int KEY_COUNT = 60;

    // [azerty, shifted][key]
    localparam logic [7:0] GLYPHS [0:3][0:KEY_COUNT-1] = '{
        '{8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
          8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
          8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
          8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
          8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
          8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
          8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
          8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
          8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
          8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
          8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h26, 8'h82, 8'h22, 8'h27, 8'h28, 8'h2D, 8'h8A, 8'h5F,
          8'h87, 8'hA0, 8'h29, 8'h3D, 8'h08, 8'h09, 8'h61, 8'h7A, 8'h65, 8'h72,
          8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5E, 8'h24, 8'h0A, 8'h00,
          8'h71, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h6D,
          8'h00, 8'h60, 8'h00, 8'h2A, 8'h77, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
          8'h2C, 8'h3B, 8'h3A, 8'h21, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
          8'h39, 8'h30, 8'h2B, 8'h00, 8'h08, 8'h09, 8'h41, 8'h5A, 8'h45, 8'h52,
          8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'hF9, 8'h9C, 8'h0A, 8'h00,
          8'h51, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h4D,
          8'h25, 8'hE6, 8'h00, 8'h23, 8'h57, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
          8'h3F, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00}
    };

    logic           azerty;
    logic           editing;
    logic           shifted;
    logic [7:0]     line_chars [0:LINE_DEPTH-1];
    logic [5:0]     line_fill;
    int             fail_tally = 0;
    editor_result_t owed_results [$];

    function automatic void apply_keystroke(input logic [7:0] code);
        logic [6:0] key;
        logic [7:0] glyph;
        key = code[6:0];
        if (key == KEY_LSHIFT) begin
            shifted = !code[7];
        end else if (key == KEY_CAPS) begin
            if (!code[7]) begin
                shifted = !shifted;
            end
        end else if (code[7] || !editing) begin
            // other releases and locked editing change nothing
        end else if (key == KEY_BACKSPACE) begin
            if (line_fill != 0) begin
                line_fill = line_fill - 6'd1;
                owed_results.push_back(editor_result_t'{KIND_ERASE, CH_ERASE, 1'b1});
            end
        end else if (key < KEY_COUNT) begin
            glyph = GLYPHS[{azerty, shifted}][key];
            if (glyph == CH_NONE) begin
                // unmapped key
            end else if (glyph == CH_NEWLINE) begin
                for (int i = 0; i < line_fill; i++) begin
                    owed_results.push_back(editor_result_t'{KIND_LINE, line_chars[i], 1'b0});
                end
                owed_results.push_back(editor_result_t'{KIND_ECHO, CH_NEWLINE, 1'b1});
                line_fill = 6'd0;
            end else if (line_fill >= LINE_DEPTH) begin
                owed_results.push_back(editor_result_t'{KIND_DROP, glyph, 1'b1});
            end else begin
                line_chars[line_fill] = glyph;
                line_fill = line_fill + 6'd1;
                owed_results.push_back(editor_result_t'{KIND_ECHO, glyph, 1'b1});
            end
        end
    endfunction

    always @(posedge aclk) begin : watch
        editor_result_t seen;
        editor_result_t want;
        if (!aresetn) begin
            azerty    = 1'b1;
            editing   = 1'b1;
            shifted   = 1'b0;
            line_fill = 6'd0;
            owed_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_LAYOUT) begin
                    azerty = cfg_wdata;
                end else begin
                    editing = cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) begin
                apply_keystroke(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                seen = editor_result_t'{m_tdata[1:0], m_tdata[9:2], m_tlast};
                if (owed_results.size() == 0) begin
                    $display("%0t unexpected result: kind %0d char %h last %b",
                             $time, seen.kind, seen.char_code, seen.last);
                    fail_tally++;
                end else begin
                    want = owed_results.pop_front();
                    if (seen != want) begin
                        $display("%0t mismatch: expected kind %0d char %h last %b, got kind %0d char %h last %b",
                                 $time, want.kind, want.char_code, want.last,
                                 seen.kind, seen.char_code, seen.last);
                        fail_tally++;
                    end
                end
            end
        end
        bad_results <= fail_tally;
        owed_count  <= owed_results.size();
    end

endmodule

[sim/scancode_line_editor_tb.sv]
// testbench top for the scan code line editor: stimulus, pacing and verdict

module scancode_line_editor_tb;
    import sle_pkg::*;

    // enter has no name in the package; the block finds it by its newline char, not by key code
    localparam logic [6:0] KEY_ENTER = 7'd28;

    // cycles to let a result-free item finish after the last result left
    localparam int SETTLE_CYCLES = 16;
    // bound on one wait for outstanding results
    localparam int DRAIN_LIMIT = 20000;

    // per-phase register settings of the random part: both layouts, both edit modes
    localparam logic PLAN_AZERTY [0:5] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    localparam logic PLAN_EDIT   [0:5] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = REG_LAYOUT;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tready  = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;
    wire         m_tlast;

    int bad_results;
    int owed_count;
    int burst_left = 0;

    // 8 time unit clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    scancode_line_editor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // watches both channels and the register port, predicts and compares
    scancode_line_editor_check i_result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .bad_results (bad_results),
        .owed_count  (owed_count)
    );

    // present one scan code and hold it until accepted, then pace the sender:
    // bursts of random length, mostly followed by a random gap
    task automatic type_code(input logic [7:0] code);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // stop sending and wait for every owed result, then let the block settle
    task automatic drain_results;
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed_count != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write both registers on back-to-back cycles, only while the block is idle
    task automatic set_mode(input logic use_azerty, input logic allow_edit);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_LAYOUT;
        cfg_wdata <= use_azerty;
        @(posedge aclk);
        cfg_addr  <= REG_ENABLE;
        cfg_wdata <= allow_edit;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // receiver pacing: spans of always ready, coin flips, long stalls and toggling
    initial begin : sink_pacing
        int style;
        int span;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(8, 80);
            repeat (span) begin
                @(posedge aclk);
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 5) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    initial begin : stimulus
        int         line_target;
        int         typed;
        int         roll;
        logic [6:0] key;
        logic       shift_held;
        shift_held = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset settings: azerty, editing on
        type_code({1'b0, KEY_BACKSPACE});     // erase on an empty line gives nothing
        type_code(8'h00);                     // key 0 is unmapped, all bits low
        type_code(8'h10);                     // plain letter, echoed and stored
        type_code(8'h90);                     // its release is ignored
        type_code({1'b0, KEY_LSHIFT});        // shift held
        type_code(8'h02);                     // upper-case digit row
        type_code(8'h1A);                     // upper-case char above 0x7f
        type_code({1'b1, KEY_LSHIFT});        // shift released
        type_code(8'h03);                     // lower-case accented char
        type_code({1'b0, KEY_CAPS});          // caps press turns shift on
        type_code({1'b1, KEY_CAPS});          // caps release changes nothing
        type_code(8'h1B);                     // shifted through caps
        type_code({1'b0, KEY_CAPS});          // caps press turns shift off again
        type_code({1'b0, KEY_BACKSPACE});     // erase of the last char
        type_code(8'h0F);                     // tab is an ordinary char
        type_code(8'h7F);                     // highest key number, unmapped
        type_code(8'h3C);                     // first key past the checker's glyph table, unmapped
        type_code(8'h01);                     // escape, unmapped
        type_code(8'hFF);                     // release with every bit high
        type_code({1'b0, KEY_ENTER});         // replay of the stored line
        type_code({1'b0, KEY_ENTER});         // empty line: newline only
        type_code({1'b1, KEY_ENTER});         // enter release ignored

        // editing locked, qwerty: chars, enter and erase give nothing, caps still toggles
        drain_results();
        set_mode(1'b0, 1'b0);
        type_code(8'h10);
        type_code({1'b0, KEY_CAPS});
        type_code({1'b0, KEY_ENTER});
        type_code({1'b0, KEY_BACKSPACE});

        // unlocked again: caps state carried over from the locked phase
        drain_results();
        set_mode(1'b0, 1'b1);
        type_code(8'h10);
        type_code({1'b0, KEY_CAPS});

        // random part: typed lines with random content, some long enough to fill
        // the line store and spill, the rest short; shift, caps, erase and noise mixed in
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            set_mode(PLAN_AZERTY[phase], PLAN_EDIT[phase]);
            for (int row = 0; row < 3; row++) begin
                if (phase % 3 == 0 && row == 0) begin
                    line_target = $urandom_range(80, 86);
                end else begin
                    line_target = $urandom_range(0, 5);
                end
                typed = 0;
                while (typed < line_target) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 6) begin
                        type_code({1'b0, KEY_BACKSPACE});
                    end else if (roll < 14) begin
                        // shift press or release, whichever flips its state
                        type_code({shift_held, KEY_LSHIFT});
                        shift_held = !shift_held;
                    end else if (roll < 18) begin
                        type_code({1'b0, KEY_CAPS});
                        if ($urandom_range(0, 1) == 1) begin
                            type_code({1'b1, KEY_CAPS});
                        end
                    end else if (roll < 23) begin
                        // noise: any byte at all
                        type_code(8'($urandom_range(0, 255)));
                    end else begin
                        // char key, never one of the control keys
                        key = 7'($urandom_range(2, 57));
                        if (key == KEY_BACKSPACE || key == KEY_ENTER || key == KEY_LSHIFT) begin
                            key = 7'd16;
                        end
                        type_code({1'b0, key});
                        if ($urandom_range(0, 4) == 0) begin
                            type_code({1'b1, key});
                        end
                        typed++;
                    end
                end
                type_code({1'b0, KEY_ENTER});
                if ($urandom_range(0, 2) == 0) begin
                    type_code({1'b1, KEY_ENTER});
                end
                // now and then hold off until the line has fully drained
                if ($urandom_range(0, 7) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        if (bad_results == 0 && owed_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit: every item replaying a full line with long receiver stalls,
    // taken several times over
    initial begin : run_limit
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
